### src/ssbs_pkg.sv
// ----------------------------------------------------------------------------
// ssbs_pkg: shared types, constants and segment tables
// Payload structs, the divide-by-ten constants and the display and bar
// pattern look-ups of the seven-segment bar serialiser.
// ----------------------------------------------------------------------------
package ssbs_pkg;

	typedef struct packed {
		logic [15:0] number;
		logic [3:0]  bar_count;
	} item_t;

	typedef struct packed {
		logic data_bit;
		logic latch;
	} result_t;

	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS);

	// x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every x below 81920
	localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
	localparam int          DIV10_SHIFT = 19;

	localparam logic [3:0] BAR_MAX = 4'd8;

	typedef logic [WORD_BITS-1:0] word_t;

	// Outer displays (hundreds, units): "PCDE--------GFAB"
	function automatic logic [15:0] outer_seg(input logic [3:0] digit);
		logic [15:0] seg;
		unique case (digit)
			4'd0:    seg = 16'h7007;
			4'd1:    seg = 16'h4001;
			4'd2:    seg = 16'h300B;
			4'd3:    seg = 16'h600B;
			4'd4:    seg = 16'h400D;
			4'd5:    seg = 16'h600E;
			4'd6:    seg = 16'h700E;
			4'd7:    seg = 16'h4003;
			4'd8:    seg = 16'h700F;
			4'd9:    seg = 16'h600F;
			default: seg = 16'h0000;
		endcase
		return seg;
	endfunction

	// Middle display (tens): "----PCDEGFAB----"
	function automatic logic [15:0] middle_seg(input logic [3:0] digit);
		logic [15:0] seg;
		unique case (digit)
			4'd0:    seg = 16'h0770;
			4'd1:    seg = 16'h0410;
			4'd2:    seg = 16'h03B0;
			4'd3:    seg = 16'h06B0;
			4'd4:    seg = 16'h04D0;
			4'd5:    seg = 16'h06E0;
			4'd6:    seg = 16'h07E0;
			4'd7:    seg = 16'h0430;
			4'd8:    seg = 16'h07F0;
			4'd9:    seg = 16'h06F0;
			default: seg = 16'h0000;
		endcase
		return seg;
	endfunction

	// Bar LEDs, thermometer code: "----43215678----"
	function automatic logic [15:0] bar_seg(input logic [3:0] count);
		logic [15:0] seg;
		unique case (count)
			4'd0:    seg = 16'h0000;
			4'd1:    seg = 16'h0100;
			4'd2:    seg = 16'h0300;
			4'd3:    seg = 16'h0700;
			4'd4:    seg = 16'h0F00;
			4'd5:    seg = 16'h0F80;
			4'd6:    seg = 16'h0FC0;
			4'd7:    seg = 16'h0FE0;
			default: seg = 16'h0FF0;
		endcase
		return seg;
	endfunction

endpackage

### src/ssbs_front.sv
// ----------------------------------------------------------------------------
// ssbs_front: digit split and word build
// Four-stage pipeline: divides the number by ten three times by reciprocal
// multiplication, peels off units, tens and hundreds, and builds the word.
// ----------------------------------------------------------------------------
module ssbs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssbs_pkg::item_t     item,
	output logic                full,
	output logic                word_valid,
	output ssbs_pkg::word_t     word,
	input  logic                word_full
);

	// Low digit of x given the low bits of x and of x / 10
	function automatic logic [3:0] rem10(input logic [3:0] x_lo, input logic [3:0] q_lo);
		logic [3:0] tq;
		tq = 4'({q_lo, 3'b000} + {q_lo, 1'b0});
		return 4'(x_lo - tq);
	endfunction

	logic        en;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [15:0] n_s1;
	logic [3:0]  bar_s1, bar_s2, bar_s3, bar_s4;
	logic [12:0] q1_s2;
	logic [3:0]  nlo_s2;
	logic [9:0]  q2_s3;
	logic [3:0]  q1lo_s3, units_s3, units_s4;
	logic [6:0]  q3_s4;
	logic [3:0]  q2lo_s4, tens_s4;
	logic [31:0] prod1;
	logic [28:0] prod2;
	logic [25:0] prod3;
	logic [3:0]  hundreds;

	// hold the whole pipe while the last stage cannot hand over
	assign en   = !(v_s4 && word_full);
	assign full = !en;

	assign prod1 = 32'(n_s1) * 32'(ssbs_pkg::DIV10_MUL);
	assign prod2 = 29'(q1_s2) * 29'(ssbs_pkg::DIV10_MUL);
	assign prod3 = 26'(q2_s3) * 26'(ssbs_pkg::DIV10_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1     <= item.number;
			bar_s1   <= (item.bar_count > ssbs_pkg::BAR_MAX) ? ssbs_pkg::BAR_MAX
			                                                 : item.bar_count;
			q1_s2    <= prod1[31:ssbs_pkg::DIV10_SHIFT];
			nlo_s2   <= n_s1[3:0];
			bar_s2   <= bar_s1;
			q2_s3    <= prod2[28:ssbs_pkg::DIV10_SHIFT];
			q1lo_s3  <= q1_s2[3:0];
			units_s3 <= rem10(nlo_s2, q1_s2[3:0]);
			bar_s3   <= bar_s2;
			q3_s4    <= prod3[25:ssbs_pkg::DIV10_SHIFT];
			q2lo_s4  <= q2_s3[3:0];
			tens_s4  <= rem10(q1lo_s3, q2_s3[3:0]);
			units_s4 <= units_s3;
			bar_s4   <= bar_s3;
		end
	end

	assign hundreds   = rem10(q2lo_s4, q3_s4[3:0]);
	assign word_valid = v_s4;
	assign word = {ssbs_pkg::outer_seg(hundreds) | ssbs_pkg::bar_seg(bar_s4),
	               ssbs_pkg::middle_seg(tens_s4) | ssbs_pkg::outer_seg(units_s4)};

endmodule

### src/ssbs_fifo.sv
// ----------------------------------------------------------------------------
// ssbs_fifo: two-entry word queue
// Decouples the word builder from the serialiser.
// ----------------------------------------------------------------------------
module ssbs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  ssbs_pkg::word_t wr_data,
	output logic            wr_full,
	input  logic            rd,
	output logic            rd_valid,
	output ssbs_pkg::word_t rd_data
);

	ssbs_pkg::word_t slot_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_wr, do_rd;

	assign wr_full  = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign do_wr    = wr && !wr_full;
	assign do_rd    = rd && rd_valid;
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, do_wr} - {1'b0, do_rd});
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

endmodule

### src/ssbs_back.sv
// ----------------------------------------------------------------------------
// ssbs_back: serialiser
// Shifts each word out LSB first, one bit per popped request, and flags
// the 32nd bit for the latch.
// ----------------------------------------------------------------------------
module ssbs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                word_valid,
	input  ssbs_pkg::word_t     word,
	output logic                word_take,
	output logic                empty,
	input  logic                pop,
	output ssbs_pkg::result_t   result
);

	ssbs_pkg::word_t          shift_q;
	logic [ssbs_pkg::CNT_W-1:0] cnt_q;
	logic                     busy_q;
	logic                     last;

	assign last      = (cnt_q == ssbs_pkg::CNT_W'(ssbs_pkg::WORD_BITS - 1));
	assign word_take = word_valid && (!busy_q || (pop && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (word_take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && pop) begin
			// drop out of busy after the last bit when no word waits
			if (last)
				busy_q <= 1'b0;
			cnt_q <= ssbs_pkg::CNT_W'(cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (word_take)
			shift_q <= word;
		else if (busy_q && pop)
			shift_q <= {1'b0, shift_q[ssbs_pkg::WORD_BITS-1:1]};
	end

	assign empty           = !busy_q;
	assign result.data_bit = shift_q[0];
	assign result.latch    = last;

endmodule

### src/seven_segment_bar_serializer.sv
// ----------------------------------------------------------------------------
// seven_segment_bar_serializer: three-digit display and bar serialiser
// Turns a number and a bar count into the 32-bit display word and shifts it
// out as serial bits.
// ----------------------------------------------------------------------------
// Each request carries a 16-bit number and a bar count (0 to 8, higher values
// light all eight bars). The last three decimal digits are shown. The block
// answers every request with 32 results, one per popped request, the display
// word least significant bit first; the 32nd result has latch set. A new word
// follows the previous one with no gap, and the serialiser shifts out one bit
// per cycle while the receiver pops every cycle. An input request passes a
// four-stage divide-by-ten pipeline and then the word queue before its first
// bit is on the result ports. Up to six requests (four in the pipeline, two in
// the word queue) may be in flight ahead of the word being shifted out.
module seven_segment_bar_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ssbs_pkg::item_t   item,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output ssbs_pkg::result_t result
);

	logic            fr_valid;
	ssbs_pkg::word_t fr_word;
	logic            fq_full;
	logic            bk_valid;
	ssbs_pkg::word_t bk_word;
	logic            bk_take;

	ssbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.word_valid (fr_valid),
		.word       (fr_word),
		.word_full  (fq_full)
	);

	ssbs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (fr_valid),
		.wr_data  (fr_word),
		.wr_full  (fq_full),
		.rd       (bk_take),
		.rd_valid (bk_valid),
		.rd_data  (bk_word)
	);

	ssbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (bk_valid),
		.word       (bk_word),
		.word_take  (bk_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

### src/ssbs_checker.sv
// ----------------------------------------------------------------------------
// ssbs_checker: port-level checks
// Watches the result side of the serialiser over time.
// ----------------------------------------------------------------------------
module ssbs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input ssbs_pkg::result_t result
);

	// an unpopped result stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result))
		else $error("result changed while waiting");

	// within a word the next bit is always ready
	a_word_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.latch) |=> !empty)
		else $error("gap inside a word");

	// a new word never starts on a latch bit
	a_latch_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && result.latch) |=> (empty || !result.latch))
		else $error("latch on two results in a row");

endmodule

bind seven_segment_bar_serializer ssbs_checker u_ssbs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

### dv/seven_segment_bar_serializer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_bar_serializer_tb: self-checking bench for the serialiser
// Feeds number and bar-count requests through the push/full side. It builds
// the expected 32-bit display word for each accepted request and checks the
// serial bits and the latch flag popped from the result side, in order.
// Both sides idle in random bursts but for a final steady run. The receiver
// also holds off once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module seven_segment_bar_serializer_tb;

	localparam int          CLK_PERIOD   = 12;
	localparam int          RESET_CYCLES = 12;
	localparam int          BITS_PER_REQ = 32;
	localparam int          HOLD_CYCLES  = 350;
	localparam int          DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 600000;

	logic              clk;
	logic              arst_n;
	logic              push;
	ssbs_pkg::item_t   item;
	logic              full;
	logic              empty;
	logic              pop;
	ssbs_pkg::result_t result;

	ssbs_pkg::item_t   pending_reqs[$];
	ssbs_pkg::result_t expected_bits[$];
	logic        req_taken;
	int          send_gap;
	int          recv_gap;
	int          hold_count;
	bit          hold_request;
	bit          hold_done;
	bit          steady_mode;
	int unsigned cycle_count;
	int unsigned reqs_accepted;
	int unsigned bits_checked;
	int unsigned full_stalls;
	int unsigned mismatches;

	seven_segment_bar_serializer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Outer displays (hundreds and units), bits "PCDE--------GFAB"
	function automatic logic [15:0] outer_pattern(input int digit);
		case (digit)
			0:       return 16'b0111_0000_0000_0111;
			1:       return 16'b0100_0000_0000_0001;
			2:       return 16'b0011_0000_0000_1011;
			3:       return 16'b0110_0000_0000_1011;
			4:       return 16'b0100_0000_0000_1101;
			5:       return 16'b0110_0000_0000_1110;
			6:       return 16'b0111_0000_0000_1110;
			7:       return 16'b0100_0000_0000_0011;
			8:       return 16'b0111_0000_0000_1111;
			default: return 16'b0110_0000_0000_1111;
		endcase
	endfunction

	// Tens display, bits "----PCDEGFAB----"
	function automatic logic [15:0] middle_pattern(input int digit);
		case (digit)
			0:       return 16'b0000_0111_0111_0000;
			1:       return 16'b0000_0100_0001_0000;
			2:       return 16'b0000_0011_1011_0000;
			3:       return 16'b0000_0110_1011_0000;
			4:       return 16'b0000_0100_1101_0000;
			5:       return 16'b0000_0110_1110_0000;
			6:       return 16'b0000_0111_1110_0000;
			7:       return 16'b0000_0100_0011_0000;
			8:       return 16'b0000_0111_1111_0000;
			default: return 16'b0000_0110_1111_0000;
		endcase
	endfunction

	// Thermometer bar; counts above eight light every LED
	function automatic logic [15:0] bar_pattern(input logic [3:0] count);
		logic [15:0] lit;
		int          n;
		n   = (count > 4'd8) ? 8 : int'(count);
		lit = '0;
		for (int k = 0; k < n; k++) begin
			lit[(k < 4) ? 8 + k : 11 - k] = 1'b1;
		end
		return lit;
	endfunction

	function automatic logic [31:0] display_word(input ssbs_pkg::item_t req);
		int          value;
		logic [31:0] word;
		value = int'(req.number);
		word  = {outer_pattern((value / 100) % 10), 16'h0000};
		word  = word | {16'h0000, middle_pattern((value / 10) % 10)};
		word  = word | {16'h0000, outer_pattern(value % 10)};
		word  = word | {bar_pattern(req.bar_count), 16'h0000};
		return word;
	endfunction

	task automatic queue_display_bits(input ssbs_pkg::item_t req);
		logic [31:0]       word;
		ssbs_pkg::result_t bit_out;
		word = display_word(req);
		for (int k = 0; k < BITS_PER_REQ; k++) begin
			bit_out.data_bit = word[k];
			bit_out.latch    = (k == BITS_PER_REQ - 1);
			expected_bits.push_back(bit_out);
		end
	endtask

	task automatic add_request(input logic [15:0] number, input logic [3:0] bars);
		ssbs_pkg::item_t req;
		req.number    = number;
		req.bar_count = bars;
		pending_reqs.push_back(req);
	endtask

	task automatic add_random_requests(input int count);
		logic [15:0] number;
		logic [3:0]  bars;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0:       number = 16'($urandom_range(0, 999));
				1:       number = 16'($urandom_range(64536, 65535));
				default: number = 16'($urandom_range(0, 65535));
			endcase
			bars = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
			                                   : 4'($urandom_range(0, 8));
			add_request(number, bars);
		end
	endtask

	task automatic wait_all_done();
		while (pending_reqs.size() != 0 || expected_bits.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Sample both handshakes; check popped bits, then record new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken   <= 1'b0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("%0t: timeout after %0d cycles", $time, cycle_count);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (pop && !empty) begin
				if (expected_bits.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %b", $time,
					         result);
					mismatches++;
				end else begin
					if (result.data_bit !== expected_bits[0].data_bit) begin
						$display("%0t: data_bit expected %b actual %b", $time,
						         expected_bits[0].data_bit, result.data_bit);
						mismatches++;
					end
					if (result.latch !== expected_bits[0].latch) begin
						$display("%0t: latch expected %b actual %b", $time,
						         expected_bits[0].latch, result.latch);
						mismatches++;
					end
					expected_bits.delete(0);
					bits_checked++;
				end
			end
			if (push && full) begin
				full_stalls++;
			end
			if (push && !full) begin
				queue_display_bits(item);
				reqs_accepted++;
			end
			req_taken <= push && !full;
		end
	end

	// Request driver: offer the head of the pending queue, idle in bursts
	always @(negedge clk) begin
		logic next_push;
		next_push = 1'b0;
		if (arst_n) begin
			if (req_taken && pending_reqs.size() != 0) begin
				pending_reqs.delete(0);
			end
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_reqs.size() != 0) begin
				next_push = 1'b1;
				if (!steady_mode && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 6);
				end
			end
		end
		push <= next_push;
		if (next_push) begin
			item <= pending_reqs[0];
		end
	end

	// Result receiver: idle in bursts, hold off once for a long stretch
	always @(negedge clk) begin
		logic next_pop;
		next_pop = 1'b0;
		if (arst_n) begin
			if (hold_request && !hold_done && hold_count == 0) begin
				hold_count = HOLD_CYCLES;
			end
			if (hold_count > 0) begin
				hold_count--;
				if (hold_count == 0) begin
					hold_done = 1'b1;
				end
			end else if (recv_gap > 0) begin
				recv_gap--;
			end else begin
				next_pop = 1'b1;
				if (!steady_mode && $urandom_range(0, 9) == 0) begin
					recv_gap = $urandom_range(1, 6);
				end
			end
		end
		pop <= next_pop;
	end

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		item          = '0;
		send_gap      = 0;
		recv_gap      = 0;
		hold_count    = 0;
		hold_request  = 1'b0;
		hold_done     = 1'b0;
		steady_mode   = 1'b0;
		reqs_accepted = 0;
		bits_checked  = 0;
		full_stalls   = 0;
		mismatches    = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Field extremes, every bar count including the saturating ones,
		// the digit eight in each position and the mod-1000 wrap
		add_request(16'd0,     4'd0);
		add_request(16'd65535, 4'd15);
		add_request(16'd888,   4'd1);
		add_request(16'd8,     4'd2);
		add_request(16'd80,    4'd3);
		add_request(16'd800,   4'd4);
		add_request(16'd999,   4'd5);
		add_request(16'd1000,  4'd6);
		add_request(16'd123,   4'd7);
		add_request(16'd456,   4'd8);
		add_request(16'd7,     4'd9);
		add_request(16'd65000, 4'd10);
		add_request(16'd10,    4'd11);
		add_request(16'd100,   4'd12);
		add_request(16'd1888,  4'd13);
		add_request(16'd65432, 4'd14);
		add_request(16'd21845, 4'd8);
		add_request(16'd43690, 4'd0);
		add_request(16'd1,     4'd15);
		add_request(16'd901,   4'd9);
		wait_all_done();

		add_random_requests(150);
		wait_all_done();

		// Stall the receiver while the sender keeps offering requests
		hold_request = 1'b1;
		add_random_requests(150);
		wait_all_done();

		steady_mode = 1'b1;
		add_random_requests(90);
		wait_all_done();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests and %0d serial bits in %0d cycles.",
		         reqs_accepted, bits_checked, cycle_count);
		$display("Input stalled by full for %0d cycles; %0d mismatches.",
		         full_stalls, mismatches);
		if (mismatches == 0 && expected_bits.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
